FILE: rtl/ilist_pkg.sv
// shared types and constants for the indexed list engine
package ilist_pkg;

   // index width: covers positions and counts up to a capacity of 4096
   localparam int IDX_W  = 13;
   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int POS_W  = 9;
   localparam int LEN_W  = 9;

   localparam logic [DATA_W-1:0] READ_NONE = '1;

   typedef enum logic [KIND_W-1:0] {
      REQ_READ     = 3'd0,
      REQ_INS_HEAD = 3'd1,
      REQ_INS_TAIL = 3'd2,
      REQ_INS_AT   = 3'd3,
      REQ_DELETE   = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_BADPOS = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GATHER
   } fsm_state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: rtl/ilist_if.sv
// request and response channel interfaces
interface ilist_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [ilist_pkg::KIND_W-1:0]               req_type;
   logic [ilist_pkg::POS_W-1:0]                position;
   logic signed [ilist_pkg::DATA_W-1:0]        value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink (input valid, input req_type, input position, input value,
                 output ready);
endinterface

interface ilist_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic [1:0]                                 status;
   logic signed [ilist_pkg::DATA_W-1:0]        read_value;
   logic [ilist_pkg::LEN_W-1:0]                length;

   modport source (output valid, output status, output read_value, output length,
                   input ready);
   modport sink (input valid, input status, input read_value, input length,
                 output ready);
endinterface

FILE: rtl/ilist_cell.sv
// one list slot: holds an element and shifts to or from its neighbors
module ilist_cell #(
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  ilist_pkg::cell_ctrl_type        ctrl,
   input  logic [ilist_pkg::DATA_W-1:0]    prev_data,
   input  logic [ilist_pkg::DATA_W-1:0]    next_data,
   output logic [ilist_pkg::DATA_W-1:0]    data,
   output logic [ilist_pkg::DATA_W-1:0]    read_data
);

   localparam logic [ilist_pkg::IDX_W-1:0] MY_IDX = INDEX[ilist_pkg::IDX_W-1:0];

   logic [ilist_pkg::DATA_W-1:0] data_ff;
   logic [ilist_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         ilist_pkg::CELL_INSERT: begin
            if (ctrl.pos == MY_IDX) begin
               data_in = ctrl.value;
            end else if (ctrl.pos < MY_IDX) begin
               data_in = prev_data;
            end
         end
         ilist_pkg::CELL_DELETE: begin
            if (ctrl.pos <= MY_IDX) begin
               data_in = next_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   // only the addressed slot puts its element on the read tree
   assign read_data = (ctrl.pos == MY_IDX) ? data_ff : '0;

endmodule

FILE: rtl/indexed_list_engine_core.sv
// indexed list engine: ordered list of signed words held in a shifting cell chain
// The list lives in a row of CAPACITY cells, one element per cell; an insert shifts
// every cell above the insert point up by one and a delete shifts the cells above
// the deleted slot down by one, all cells moving together in the same clock. Each
// request goes through three steps from acceptance to a result in the output
// register: capturing the beat, an exec step in which an insert or delete shifts
// the chain and the addressed cell is collected into registered groups of 64, and
// a gather step that merges the groups and forms the response. The block works on
// one request at a time; the next request beat is taken as soon as the response
// is in the output register, even while that response still waits for the sink.
// Reads at or beyond the count return -1 with a bad-position status, inserts need
// a position at most the count (equal to the count appends) and are rejected with
// a full status once CAPACITY is reached. Reset clears the count, not the contents.
module indexed_list_engine_core #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   ilist_req_if.sink   req_chan,
   ilist_rsp_if.source rsp_chan
);

   localparam int IW   = ilist_pkg::IDX_W;
   localparam int DW   = ilist_pkg::DATA_W;
   localparam int CW   = $clog2(CAPACITY + 1);
   // read collection: cells OR-ed in groups, groups registered, then merged
   localparam int GRP  = 64;
   localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

   // fsm
   ilist_pkg::fsm_state_type state_ff, state_in;

   // captured request beat
   logic [ilist_pkg::KIND_W-1:0] kind_ff;
   logic [ilist_pkg::POS_W-1:0]  pos_ff;
   logic [DW-1:0]                val_ff;

   // list count
   logic [CW-1:0] count_ff, count_in;

   // outcome of the exec cycle
   ilist_pkg::status_type stat_ff, stat_in;
   logic                  rdok_ff, rdok_in;

   // read tree
   logic [DW-1:0] grp_ff [NGRP];
   logic [DW-1:0] grp_in [NGRP];
   logic [DW-1:0] read_word;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   ilist_pkg::status_type rsp_stat_ff;
   logic [DW-1:0]         rsp_data_ff;
   logic [ilist_pkg::LEN_W-1:0] rsp_len_ff;
   logic                  rsp_load;

   // cell chain
   ilist_pkg::cell_ctrl_type ctrl;
   logic [DW-1:0] cell_data [CAPACITY];
   logic [DW-1:0] cell_rd   [NGRP*GRP];

   logic [IW-1:0] pos_ext;
   logic [IW-1:0] cnt_ext;
   logic [IW-1:0] ins_pos;
   logic          is_insert;
   logic          full;
   logic          accept;
   logic          out_free;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ilist_pkg::ST_IDLE);

   assign pos_ext = IW'(pos_ff);
   assign cnt_ext = IW'(count_ff);
   assign full    = (cnt_ext == IW'(CAPACITY));

   // decode the request against the current count, drive the chain
   always_comb begin
      ctrl.op    = ilist_pkg::CELL_HOLD;
      ctrl.pos   = pos_ext;
      ctrl.value = val_ff;
      count_in   = count_ff;
      stat_in    = ilist_pkg::STAT_BADPOS;
      rdok_in    = 1'b0;
      is_insert  = 1'b0;
      ins_pos    = pos_ext;

      unique case (ilist_pkg::req_kind_type'(kind_ff))
         ilist_pkg::REQ_READ: begin
            if (pos_ext < cnt_ext) begin
               stat_in = ilist_pkg::STAT_DONE;
               rdok_in = 1'b1;
            end
         end
         ilist_pkg::REQ_INS_HEAD: begin
            is_insert = 1'b1;
            ins_pos   = '0;
         end
         ilist_pkg::REQ_INS_TAIL: begin
            is_insert = 1'b1;
            ins_pos   = cnt_ext;
         end
         ilist_pkg::REQ_INS_AT: begin
            is_insert = 1'b1;
            ins_pos   = pos_ext;
         end
         ilist_pkg::REQ_DELETE: begin
            if (pos_ext < cnt_ext) begin
               stat_in = ilist_pkg::STAT_DONE;
               if (state_ff == ilist_pkg::ST_EXEC) begin
                  ctrl.op  = ilist_pkg::CELL_DELETE;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: stat_in = ilist_pkg::STAT_BADPOS;
      endcase

      // position check comes before the full check
      if (is_insert) begin
         ctrl.pos = ins_pos;
         if (ins_pos > cnt_ext) begin
            stat_in = ilist_pkg::STAT_BADPOS;
         end else if (full) begin
            stat_in = ilist_pkg::STAT_FULL;
         end else begin
            stat_in = ilist_pkg::STAT_DONE;
            if (state_ff == ilist_pkg::ST_EXEC) begin
               ctrl.op  = ilist_pkg::CELL_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
      end
   end

   // the chain itself: each cell sees its lower and upper neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DW-1:0] prev_w;
      logic [DW-1:0] next_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_prev
         assign prev_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_next
         assign next_w = cell_data[i+1];
      end
      ilist_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .prev_data (prev_w),
         .next_data (next_w),
         .data      (cell_data[i]),
         .read_data (cell_rd[i])
      );
   end

   // pad the read tree up to a whole number of groups
   for (genvar i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
      assign cell_rd[i] = '0;
   end

   // first level of the read tree, registered in the exec cycle
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            grp_in[g] = grp_in[g] | cell_rd[g*GRP + k];
         end
      end
   end

   // second level, merged in the gather cycle
   always_comb begin
      read_word = '0;
      for (int g = 0; g < NGRP; g++) begin
         read_word = read_word | grp_ff[g];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ilist_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ilist_pkg::ST_EXEC;
            end
         end
         ilist_pkg::ST_EXEC: begin
            state_in = ilist_pkg::ST_GATHER;
         end
         ilist_pkg::ST_GATHER: begin
            // wait here while the previous response is still held
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ilist_pkg::ST_IDLE;
            end
         end
         default: state_in = ilist_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilist_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ilist_pkg::ST_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_chan.req_type;
         pos_ff  <= req_chan.position;
         val_ff  <= req_chan.value;
      end
      if (state_ff == ilist_pkg::ST_EXEC) begin
         stat_ff <= stat_in;
         rdok_ff <= rdok_in;
         for (int g = 0; g < NGRP; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
      if (rsp_load) begin
         rsp_stat_ff <= stat_ff;
         rsp_data_ff <= rdok_ff ? read_word : ilist_pkg::READ_NONE;
         // count already updated in the exec cycle
         rsp_len_ff  <= cnt_ext[ilist_pkg::LEN_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_stat_ff;
   assign rsp_chan.read_value = rsp_data_ff;
   assign rsp_chan.length     = rsp_len_ff;

endmodule
